FILE: sv/sqt_pkg.sv
// Shared types and constants of the search query tokenizer.
// Used by every module of the block; no dependencies.
`default_nettype none

package sqt_pkg;

  localparam int unsigned CpW = 21;

  localparam logic [CpW-1:0] ChMinus  = 21'h00002D;
  localparam logic [CpW-1:0] ChSpace  = 21'h000020;
  localparam logic [CpW-1:0] ChBslash = 21'h00005C;
  localparam logic [CpW-1:0] ChQuote  = 21'h000022;
  localparam logic [CpW-1:0] ChStar   = 21'h00002A;

  // Parser modes
  localparam logic [1:0] ModeStart = 2'd0;
  localparam logic [1:0] ModeToken = 2'd1;
  localparam logic [1:0] ModeEsc   = 2'd2;
  localparam logic [1:0] ModeSkip  = 2'd3;

  typedef enum logic [1:0] {
    MkExact  = 2'd0,
    MkPrefix = 2'd1,
    MkSuffix = 2'd2,
    MkBoth   = 2'd3
  } match_kind_e;

  // Class of a code point as the parser sees it
  typedef enum logic [2:0] {
    ClsOther  = 3'd0,
    ClsMinus  = 3'd1,
    ClsSpace  = 3'd2,
    ClsBslash = 3'd3,
    ClsQuote  = 3'd4,
    ClsStar   = 3'd5
  } char_cls_e;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           is_end;
    logic           decode_error;
  } in_word_t;

  typedef struct packed {
    logic           char_valid;
    logic [CpW-1:0] token_char;
    logic           token_end;
    logic [1:0]     match_kind;
    logic           is_difference;
    logic           token_cancel;
  } out_word_t;

  typedef struct packed {
    char_cls_e      cls;
    logic [CpW-1:0] code_point;
    logic           is_end;
    logic           decode_error;
  } q_entry_t;

endpackage

`default_nettype wire

FILE: sv/search_query_tokenizer_top.sv
// Top level of the search query tokenizer: front end, queue, back end.
// Depends on sqt_pkg, sqt_front, sqt_queue and sqt_back.
//
//   channel  direction  handshake                payload
//   in       input      in_valid_i / in_ready_o  in_word_i  (sqt_pkg::in_word_t)
//   out      output     out_valid_o / out_ready_i out_word_o (sqt_pkg::out_word_t)
//
// One word per cycle sustained unless the output stalls; each accepted word is
// queued, and its parser step loads any result it makes into the output register.
// The back-end parser takes one queued word per cycle unless its output stalls.
// Reset clears parser state, queue and output valid; no clearing pass.
// A stalled output holds its word while up to two input words wait in the queue.
`default_nettype none

module search_query_tokenizer_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire sqt_pkg::in_word_t  in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output sqt_pkg::out_word_t      out_word_o
);

  logic              q_full, q_push, q_pop, q_valid;
  sqt_pkg::q_entry_t q_in, q_out;

  sqt_front u_front (
    .in_valid_i (in_valid_i),
    .in_word_i  (in_word_i),
    .in_ready_o (in_ready_o),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .entry_o    (q_in)
  );

  sqt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_out)
  );

  sqt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_out),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

FILE: sv/sqt_front.sv
// Front end: accepts input words and classifies each code point.
// Depends on sqt_pkg; feeds sqt_queue.
`default_nettype none

module sqt_front (
  input  wire logic             in_valid_i,
  input  wire sqt_pkg::in_word_t in_word_i,
  output logic                  in_ready_o,
  input  wire logic             q_full_i,
  output logic                  push_o,
  output sqt_pkg::q_entry_t     entry_o
);

  sqt_pkg::char_cls_e cls;

  always_comb begin
    case (in_word_i.code_point)
      sqt_pkg::ChMinus:  cls = sqt_pkg::ClsMinus;
      sqt_pkg::ChSpace:  cls = sqt_pkg::ClsSpace;
      sqt_pkg::ChBslash: cls = sqt_pkg::ClsBslash;
      sqt_pkg::ChQuote:  cls = sqt_pkg::ClsQuote;
      sqt_pkg::ChStar:   cls = sqt_pkg::ClsStar;
      default:           cls = sqt_pkg::ClsOther;
    endcase
  end

  assign in_ready_o           = !q_full_i;
  assign push_o               = in_valid_i && !q_full_i;
  assign entry_o.cls          = cls;
  assign entry_o.code_point   = in_word_i.code_point;
  assign entry_o.is_end       = in_word_i.is_end;
  assign entry_o.decode_error = in_word_i.decode_error;

endmodule

`default_nettype wire

FILE: sv/sqt_queue.sv
// Two-entry queue of classified words between front and back end.
// Depends on sqt_pkg.
`default_nettype none

module sqt_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire sqt_pkg::q_entry_t entry_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   valid_o,
  output sqt_pkg::q_entry_t      entry_o
);

  sqt_pkg::q_entry_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> count_q != 2'd0)
    else $error("queue popped while empty");
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> count_q != 2'd2)
    else $error("queue pushed while full");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with empty count");
`endif

endmodule

`default_nettype wire

FILE: sv/sqt_back.sv
// Back end: token parser state machine with a registered output word.
// Depends on sqt_pkg; reads words from sqt_queue.
`default_nettype none

module sqt_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              q_valid_i,
  input  wire sqt_pkg::q_entry_t q_entry_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output sqt_pkg::out_word_t     out_word_o
);

  logic [1:0]              mode_q, mode_d;
  logic                    diff_q, diff_d;
  logic                    quoted_q, quoted_d;
  logic                    lead_star_q, lead_star_d;
  logic                    any_q, any_d;
  logic                    held_v_q, held_v_d;
  logic [sqt_pkg::CpW-1:0] held_char_q, held_char_d;
  logic                    out_valid_q;
  sqt_pkg::out_word_t      out_word_q, res;
  logic                    gen, do_app, do_fin, do_clr, drop;
  sqt_pkg::match_kind_e    kind;

  assign pop_o = q_valid_i && (!out_valid_q || out_ready_i);

  // Strip a trailing quote or star and work out the match kind
  always_comb begin
    if (quoted_q) begin
      drop = held_v_q && (held_char_q == sqt_pkg::ChQuote);
      kind = sqt_pkg::MkExact;
    end else begin
      drop = held_v_q && (held_char_q == sqt_pkg::ChStar);
      if (lead_star_q && !drop) begin
        kind = sqt_pkg::MkSuffix;
      end else if (!lead_star_q && drop) begin
        kind = sqt_pkg::MkPrefix;
      end else begin
        kind = sqt_pkg::MkBoth;
      end
    end
  end

  always_comb begin
    mode_d      = mode_q;
    diff_d      = diff_q;
    quoted_d    = quoted_q;
    lead_star_d = lead_star_q;
    any_d       = any_q;
    held_v_d    = held_v_q;
    held_char_d = held_char_q;
    gen         = 1'b0;
    res         = '0;
    do_app      = 1'b0;
    do_fin      = 1'b0;
    do_clr      = 1'b0;

    if (q_entry_i.decode_error) begin
      if (mode_q != sqt_pkg::ModeSkip && any_q) begin
        gen              = 1'b1;
        res.token_cancel = 1'b1;
      end
      do_clr = 1'b1;
      diff_d = 1'b0;
      mode_d = q_entry_i.is_end ? sqt_pkg::ModeStart : sqt_pkg::ModeSkip;
    end else if (q_entry_i.is_end) begin
      do_fin = (mode_q == sqt_pkg::ModeToken || mode_q == sqt_pkg::ModeEsc) && any_q;
      do_clr = 1'b1;
      diff_d = 1'b0;
      mode_d = sqt_pkg::ModeStart;
    end else begin
      case (mode_q)
        sqt_pkg::ModeStart: begin
          case (q_entry_i.cls)
            sqt_pkg::ClsMinus:  diff_d = 1'b1;
            sqt_pkg::ClsSpace:  diff_d = 1'b0;
            sqt_pkg::ClsBslash: mode_d = sqt_pkg::ModeEsc;
            default: begin
              mode_d = sqt_pkg::ModeToken;
              do_app = 1'b1;
            end
          endcase
        end
        sqt_pkg::ModeToken: begin
          case (q_entry_i.cls)
            sqt_pkg::ClsBslash: mode_d = sqt_pkg::ModeEsc;
            sqt_pkg::ClsSpace: begin
              do_fin = 1'b1;
              do_clr = 1'b1;
              diff_d = 1'b0;
              mode_d = sqt_pkg::ModeStart;
            end
            default: do_app = 1'b1;
          endcase
        end
        sqt_pkg::ModeEsc: begin
          mode_d = sqt_pkg::ModeToken;
          do_app = 1'b1;
        end
        default: ;
      endcase
    end

    if (do_fin) begin
      gen               = 1'b1;
      res.char_valid    = held_v_q && !drop;
      res.token_char    = (held_v_q && !drop) ? held_char_q : '0;
      res.token_end     = 1'b1;
      res.match_kind    = kind;
      res.is_difference = diff_q;
    end

    // First character may be a leading quote or star; later ones push out the held one
    if (do_app) begin
      if (!any_q) begin
        any_d = 1'b1;
        if (q_entry_i.cls == sqt_pkg::ClsQuote) begin
          quoted_d = 1'b1;
        end else if (q_entry_i.cls == sqt_pkg::ClsStar) begin
          lead_star_d = 1'b1;
        end else begin
          held_char_d = q_entry_i.code_point;
          held_v_d    = 1'b1;
        end
      end else begin
        if (held_v_q) begin
          gen            = 1'b1;
          res.char_valid = 1'b1;
          res.token_char = held_char_q;
        end
        held_char_d = q_entry_i.code_point;
        held_v_d    = 1'b1;
      end
    end

    if (do_clr) begin
      quoted_d    = 1'b0;
      lead_star_d = 1'b0;
      any_d       = 1'b0;
      held_v_d    = 1'b0;
      held_char_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= sqt_pkg::ModeStart;
      diff_q      <= 1'b0;
      quoted_q    <= 1'b0;
      lead_star_q <= 1'b0;
      any_q       <= 1'b0;
      held_v_q    <= 1'b0;
      held_char_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        mode_q      <= mode_d;
        diff_q      <= diff_d;
        quoted_q    <= quoted_d;
        lead_star_q <= lead_star_d;
        any_q       <= any_d;
        held_v_q    <= held_v_d;
        held_char_q <= held_char_d;
      end
      if (!out_valid_q || out_ready_i) begin
        out_valid_q <= pop_o && gen;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && gen) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) held_v_q |-> any_q)
    else $error("held character without token start");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(quoted_q && lead_star_q))
    else $error("token both quoted and star-led");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_word_q.token_cancel) |->
      (!out_word_q.char_valid && !out_word_q.token_end))
    else $error("cancel word carries token data");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && q_entry_i.decode_error && !q_entry_i.is_end) |=>
      (mode_q == sqt_pkg::ModeSkip))
    else $error("decode error did not enter skip mode");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == sqt_pkg::ModeToken) |-> any_q)
    else $error("in-token mode with empty token");
`endif

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// Testbench of the search query tokenizer: directed table, then random queries.
// Depends on sqt_pkg and search_query_tokenizer_top; carries its own token predictor.

module tb_top;

  typedef logic [sqt_pkg::CpW-1:0] cp_t;

  localparam int unsigned RandomItems = 1750;
  localparam int unsigned IdlePct     = 7;
  localparam int unsigned SendCalmLo  = 600;
  localparam int unsigned SendCalmHi  = 1000;
  localparam int unsigned RecvCalmLo  = 300;
  localparam int unsigned RecvCalmHi  = 700;
  localparam int unsigned HoldAt      = 1400;
  localparam int unsigned HoldLen     = 60;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned StallLimit  = 500;

  localparam cp_t CpTop = 21'h1FFFFF;

  localparam sqt_pkg::in_word_t EndWord    = '{code_point: '0, is_end: 1'b1,
                                               decode_error: 1'b0};
  localparam sqt_pkg::in_word_t ErrWord    = '{code_point: '0, is_end: 1'b0,
                                               decode_error: 1'b1};
  localparam sqt_pkg::in_word_t ErrEndWord = '{code_point: '0, is_end: 1'b1,
                                               decode_error: 1'b1};

  localparam sqt_pkg::out_word_t NoWord     = '0;
  localparam sqt_pkg::out_word_t CancelWord = '{char_valid: 1'b0, token_char: '0,
                                                token_end: 1'b0,
                                                match_kind: sqt_pkg::MkExact,
                                                is_difference: 1'b0,
                                                token_cancel: 1'b1};

  typedef struct {
    sqt_pkg::in_word_t  word;
    bit                 typed;
    bit                 want_has;
    sqt_pkg::out_word_t want;
  } stim_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid;
  logic               in_ready;
  sqt_pkg::in_word_t  in_word;
  logic               out_valid;
  logic               out_ready;
  sqt_pkg::out_word_t out_word;

  stim_t              stim_q[$];
  sqt_pkg::out_word_t due_words[$];
  int                 mismatches = 0;
  int                 stall_cycles = 0;

  // Predictor state
  logic [1:0] pm;
  logic       diff_q, quoted_q, lstar_q, any_q, held_v;
  cp_t        held_c;

  search_query_tokenizer_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic clear_token();
    quoted_q = 1'b0;
    lstar_q  = 1'b0;
    any_q    = 1'b0;
    held_v   = 1'b0;
    held_c   = '0;
  endtask

  task automatic forget_query();
    pm     = sqt_pkg::ModeStart;
    diff_q = 1'b0;
    clear_token();
  endtask

  function automatic sqt_pkg::out_word_t closing_word();
    sqt_pkg::out_word_t   r;
    logic                 drop;
    sqt_pkg::match_kind_e mk;
    r = '0;
    if (quoted_q) begin
      drop = held_v && held_c == sqt_pkg::ChQuote;
      mk   = sqt_pkg::MkExact;
    end else begin
      drop = held_v && held_c == sqt_pkg::ChStar;
      if (lstar_q && !drop) mk = sqt_pkg::MkSuffix;
      else if (!lstar_q && drop) mk = sqt_pkg::MkPrefix;
      else mk = sqt_pkg::MkBoth;
    end
    r.token_end     = 1'b1;
    r.match_kind    = mk;
    r.is_difference = diff_q;
    if (held_v && !drop) begin
      r.char_valid = 1'b1;
      r.token_char = held_c;
    end
    return r;
  endfunction

  // Store one character; the one held back goes out once a successor arrives
  task automatic store_char(input cp_t c, output bit has, output sqt_pkg::out_word_t r);
    has = 1'b0;
    r   = '0;
    if (!any_q) begin
      any_q = 1'b1;
      if (c == sqt_pkg::ChQuote) quoted_q = 1'b1;
      else if (c == sqt_pkg::ChStar) lstar_q = 1'b1;
      else begin
        held_c = c;
        held_v = 1'b1;
      end
    end else begin
      if (held_v) begin
        has          = 1'b1;
        r.char_valid = 1'b1;
        r.token_char = held_c;
      end
      held_c = c;
      held_v = 1'b1;
    end
  endtask

  task automatic tokenize_step(input sqt_pkg::in_word_t w, output bit has,
                               output sqt_pkg::out_word_t r);
    cp_t c;
    c   = w.code_point;
    has = 1'b0;
    r   = '0;
    if (w.decode_error) begin
      if (pm != sqt_pkg::ModeSkip && any_q) begin
        has = 1'b1;
        r   = CancelWord;
      end
      clear_token();
      diff_q = 1'b0;
      pm     = w.is_end ? sqt_pkg::ModeStart : sqt_pkg::ModeSkip;
    end else if (w.is_end) begin
      if ((pm == sqt_pkg::ModeToken || pm == sqt_pkg::ModeEsc) && any_q) begin
        has = 1'b1;
        r   = closing_word();
      end
      forget_query();
    end else begin
      case (pm)
        sqt_pkg::ModeStart: begin
          if (c == sqt_pkg::ChMinus) diff_q = 1'b1;
          else if (c == sqt_pkg::ChSpace) diff_q = 1'b0;
          else if (c == sqt_pkg::ChBslash) pm = sqt_pkg::ModeEsc;
          else begin
            pm = sqt_pkg::ModeToken;
            store_char(c, has, r);
          end
        end
        sqt_pkg::ModeToken: begin
          if (c == sqt_pkg::ChBslash) pm = sqt_pkg::ModeEsc;
          else if (c == sqt_pkg::ChSpace) begin
            has    = 1'b1;
            r      = closing_word();
            diff_q = 1'b0;
            clear_token();
            pm     = sqt_pkg::ModeStart;
          end else store_char(c, has, r);
        end
        sqt_pkg::ModeEsc: begin
          pm = sqt_pkg::ModeToken;
          store_char(c, has, r);
        end
        default: ;
      endcase
    end
  endtask

  function automatic sqt_pkg::in_word_t cp_word(cp_t c);
    sqt_pkg::in_word_t w;
    w            = '0;
    w.code_point = c;
    return w;
  endfunction

  function automatic sqt_pkg::in_word_t noise_word();
    sqt_pkg::in_word_t w;
    w.code_point   = cp_t'($urandom_range(0, CpTop));
    w.is_end       = ($urandom_range(0, 7) == 0);
    w.decode_error = ($urandom_range(0, 7) == 0);
    return w;
  endfunction

  function automatic cp_t body_char();
    cp_t c;
    case ($urandom_range(0, 15))
      0: c = sqt_pkg::ChSpace;
      1: c = sqt_pkg::ChBslash;
      2: c = sqt_pkg::ChQuote;
      3: c = sqt_pkg::ChStar;
      4: c = sqt_pkg::ChMinus;
      5: c = cp_t'($urandom_range(0, CpTop));
      6: c = $urandom_range(0, 1) ? CpTop : '0;
      default: c = cp_t'(32'h61 + $urandom_range(0, 25));
    endcase
    return c;
  endfunction

  task automatic offer(input sqt_pkg::in_word_t w);
    stim_t s;
    s.word     = w;
    s.typed    = 1'b0;
    s.want_has = 1'b0;
    s.want     = NoWord;
    stim_q     = {stim_q, s};
  endtask

  task automatic offer_typed(input sqt_pkg::in_word_t w, input bit has,
                             input sqt_pkg::out_word_t want);
    stim_t s;
    s.word     = w;
    s.typed    = 1'b1;
    s.want_has = has;
    s.want     = want;
    stim_q     = {stim_q, s};
  endtask

  // Mostly well-formed queries with random content, broken ones and noise mixed in
  task automatic compose_query();
    int unsigned ntok;
    int unsigned tail;
    ntok = $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) offer(cp_word(sqt_pkg::ChSpace));
    for (int unsigned t = 0; t < ntok; t++) begin
      if (t != 0) repeat ($urandom_range(1, 2)) offer(cp_word(sqt_pkg::ChSpace));
      case ($urandom_range(0, 5))
        0, 1: offer(cp_word(sqt_pkg::ChMinus));
        2: begin
          offer(cp_word(sqt_pkg::ChMinus));
          offer(cp_word(sqt_pkg::ChSpace));
        end
        default: ;
      endcase
      case ($urandom_range(0, 3))
        0: offer(cp_word(sqt_pkg::ChQuote));
        1: offer(cp_word(sqt_pkg::ChStar));
        default: ;
      endcase
      repeat ($urandom_range(0, 4)) begin
        if ($urandom_range(0, 9) == 0) offer(cp_word(sqt_pkg::ChBslash));
        offer(cp_word(body_char()));
      end
      case ($urandom_range(0, 4))
        0: offer(cp_word(sqt_pkg::ChQuote));
        1: offer(cp_word(sqt_pkg::ChStar));
        2: offer(cp_word(sqt_pkg::ChBslash));
        default: ;
      endcase
    end
    tail = $urandom_range(0, 19);
    if (tail < 16) offer(EndWord);
    else if (tail < 18) begin
      offer(ErrWord);
      repeat ($urandom_range(0, 3)) offer(noise_word());
      offer(EndWord);
    end else if (tail == 18) offer(ErrEndWord);
    if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 4)) offer(noise_word());
  endtask

  // Sender: reset, stimulus, drain, verdict
  initial begin
    stim_t              s;
    bit                 has;
    sqt_pkg::out_word_t got;
    int unsigned        n_dir;
    rst_ni   = 1'b0;
    in_valid = 1'b0;
    in_word  = '0;
    forget_query();

    offer_typed(EndWord, 1'b0, NoWord);
    offer(cp_word(sqt_pkg::ChMinus));
    offer(cp_word(sqt_pkg::ChStar));
    offer(cp_word(CpTop));
    offer(cp_word(sqt_pkg::ChStar));
    offer_typed(cp_word(sqt_pkg::ChSpace), 1'b1,
                '{char_valid: 1'b0, token_char: '0, token_end: 1'b1,
                  match_kind: sqt_pkg::MkBoth, is_difference: 1'b1,
                  token_cancel: 1'b0});
    offer(cp_word(sqt_pkg::ChMinus));
    offer(cp_word(sqt_pkg::ChSpace));
    offer(cp_word(21'h78));
    offer(cp_word(sqt_pkg::ChMinus));
    offer(cp_word(sqt_pkg::ChBslash));
    offer(cp_word(sqt_pkg::ChSpace));
    offer(EndWord);
    offer(cp_word(sqt_pkg::ChQuote));
    offer(cp_word(sqt_pkg::ChStar));
    offer_typed(ErrWord, 1'b1, CancelWord);
    offer(cp_word(21'h71));
    offer(ErrWord);
    offer(EndWord);
    offer_typed(ErrWord, 1'b0, NoWord);
    offer(EndWord);
    offer(cp_word(sqt_pkg::ChBslash));
    offer_typed(EndWord, 1'b0, NoWord);
    offer(cp_word(21'h7A));
    offer_typed(ErrEndWord, 1'b1, CancelWord);
    offer(cp_word('0));
    offer(cp_word(sqt_pkg::ChStar));
    offer(cp_word(sqt_pkg::ChSpace));
    offer(cp_word(sqt_pkg::ChQuote));
    offer(EndWord);

    n_dir = stim_q.size();
    while (stim_q.size() < n_dir + RandomItems) compose_query();

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < stim_q.size(); i++) begin
      s = stim_q[i];
      @(negedge clk_i);
      while (!(i >= SendCalmLo && i < SendCalmHi) && $urandom_range(0, 99) < IdlePct) begin
        in_valid <= 1'b0;
        @(negedge clk_i);
      end
      in_valid <= 1'b1;
      in_word  <= s.word;
      @(posedge clk_i);
      while (!in_ready) @(posedge clk_i);
      tokenize_step(s.word, has, got);
      if (s.typed) begin
        has = s.want_has;
        got = s.want;
      end
      if (has) due_words = {due_words, got};
    end
    @(negedge clk_i);
    in_valid <= 1'b0;

    while (due_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // Receiver: random stalls, a calm stretch, and one long hold-off to fill the block
  initial begin
    int unsigned cyc;
    int unsigned hold;
    cyc       = 0;
    hold      = 0;
    out_ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc == HoldAt) hold = HoldLen;
      if (hold != 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (cyc >= RecvCalmLo && cyc < RecvCalmHi) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(0, 99) >= IdlePct);
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    sqt_pkg::out_word_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (due_words.size() == 0) begin
        $display("%0t: unexpected word: expected none, got %h", $time, out_word);
        mismatches++;
      end else begin
        want = due_words.pop_front();
        check_field("char_valid", 32'(want.char_valid), 32'(out_word.char_valid));
        check_field("token_char", 32'(want.token_char), 32'(out_word.token_char));
        check_field("token_end", 32'(want.token_end), 32'(out_word.token_end));
        check_field("match_kind", 32'(want.match_kind), 32'(out_word.match_kind));
        check_field("is_difference", 32'(want.is_difference),
                    32'(out_word.is_difference));
        check_field("token_cancel", 32'(want.token_cancel), 32'(out_word.token_cancel));
      end
    end
  end

  // Watchdog: count cycles with no word moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else if (stall_cycles == StallLimit) begin
      $display("tb: failure");
      $finish;
    end else stall_cycles <= stall_cycles + 1;
  end

endmodule
